/* sv/ans_pkg.sv */
// shared types, constants and helper functions for the annex b nal unit splitter
`timescale 1ns / 1ps

package ans_pkg;

  // apb register file
  localparam int ANS_DATA_W  = 32;
  localparam int ANS_PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_CODEC_SELECT = 2'd0,
    REG_KEEP_START   = 2'd1,
    REG_REPEAT_SETS  = 2'd2
  } ans_reg_t;

  // result queue write side: at most eight entries come out of one byte
  localparam int ANS_MAX_PUSH = 8;
  localparam int ANS_PIDX_W   = 3;
  localparam int ANS_PCNT_W   = 4;
  // at most four content bytes are handed over per input byte
  localparam int ANS_MAX_ADDS = 4;

  // result queue size: room for two bursts in flight on top of the ready level
  localparam int ANS_QUEUE_DEPTH = 32;

  // byte stream codes
  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [1:0] ZERO_RUN_MAX   = 2'd3;
  localparam logic [1:0] PROFILE_BYTES  = 2'd3;

  // header byte fields
  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK = 8'h7E;

  localparam logic [5:0] H264_IDR       = 6'd5;
  localparam logic [5:0] H264_SPS       = 6'd7;
  localparam logic [5:0] H264_PPS       = 6'd8;
  localparam logic [5:0] H265_IDR_RADL  = 6'd19;
  localparam logic [5:0] H265_IDR_NLP   = 6'd20;
  localparam logic [5:0] H265_VPS       = 6'd32;
  localparam logic [5:0] H265_SPS       = 6'd33;
  localparam logic [5:0] H265_PPS       = 6'd34;

  // parameter set bits
  localparam int SEEN_VPS = 0;
  localparam int SEEN_SPS = 1;
  localparam int SEEN_PPS = 2;
  localparam logic [2:0] NEED_H264 = 3'b110;
  localparam logic [2:0] NEED_H265 = 3'b111;

  typedef struct packed {
    logic codec_select;
    logic keep_start_code;
    logic repeat_parameter_sets;
  } ans_cfg_t;

  typedef struct packed {
    logic        inside_unit;
    logic        header_pending;
    logic        code_long;
    logic        unit_due;
    logic [5:0]  current_type;
    logic [1:0]  delay_valid;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic        held_first;
    logic [1:0]  profile_bytes_left;
    logic [23:0] profile_capture;
    logic [23:0] profile_value;
    logic [2:0]  seen_sets;
  } ans_state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [5:0]  utype;
    logic        is_first;
    logic        is_last;
    logic        pkt_last;
    logic        due;
    logic        ready;
    logic [23:0] prof;
  } ans_entry_t;

  typedef struct packed {
    logic [ANS_PCNT_W-1:0]            cnt;
    ans_entry_t [ANS_MAX_PUSH-1:0]    ent;
  } ans_push_t;

  function automatic logic sets_known(input logic [2:0] seen, input logic codec);
    logic [2:0] need;
    need = codec ? NEED_H265 : NEED_H264;
    return (seen & need) == need;
  endfunction

  function automatic ans_entry_t make_entry(input ans_state_t st, input ans_cfg_t cfg,
                                            input logic [7:0] data, input logic is_first,
                                            input logic is_last, input logic pkt_last);
    ans_entry_t e;
    e.data     = data;
    e.utype    = st.current_type;
    e.is_first = is_first;
    e.is_last  = is_last;
    e.pkt_last = pkt_last;
    e.due      = st.unit_due;
    e.ready    = sets_known(st.seen_sets, cfg.codec_select);
    e.prof     = st.profile_value;
    return e;
  endfunction

endpackage

/* sv/ans_if.sv */
// valid/ready stream interfaces for the byte input and the tagged byte output
`timescale 1ns / 1ps

interface ans_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       packet_end;

  modport source (output valid, output in_byte, output packet_end, input ready);
  modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

interface ans_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [5:0]  unit_type;
  logic        unit_first;
  logic        unit_last;
  logic        packet_last;
  logic        config_due;
  logic        sets_ready;
  logic [23:0] profile_level;

  modport source (output valid, output out_byte, output unit_type, output unit_first,
                  output unit_last, output packet_last, output config_due,
                  output sets_ready, output profile_level, input ready);
  modport sink   (input valid, input out_byte, input unit_type, input unit_first,
                  input unit_last, input packet_last, input config_due,
                  input sets_ready, input profile_level, output ready);
endinterface

/* sv/ans_apb_regs.sv */
// apb configuration registers: codec select, start code keep, set repetition
`timescale 1ns / 1ps

module ans_apb_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ans_pkg::ANS_PADDR_W-1:0]    paddr,
  input  logic [ans_pkg::ANS_DATA_W-1:0]     pwdata,
  output logic [ans_pkg::ANS_DATA_W-1:0]     prdata,
  output logic                               pready,
  output ans_pkg::ans_cfg_t                  cfg
);
  import ans_pkg::*;

  ans_cfg_t cfg_r;
  ans_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ans_reg_t'(paddr[ANS_PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CODEC_SELECT: cfg_r.codec_select          <= pwdata[0];
        REG_KEEP_START:   cfg_r.keep_start_code       <= pwdata[0];
        REG_REPEAT_SETS:  cfg_r.repeat_parameter_sets <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CODEC_SELECT: prdata = ANS_DATA_W'(cfg_r.codec_select);
      REG_KEEP_START:   prdata = ANS_DATA_W'(cfg_r.keep_start_code);
      REG_REPEAT_SETS:  prdata = ANS_DATA_W'(cfg_r.repeat_parameter_sets);
      default:          prdata = '0;
    endcase
  end

endmodule

/* sv/ans_step.sv */
// input byte register and single pass start code / unit tagging logic
`timescale 1ns / 1ps

module ans_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               packet_end,
  input  ans_pkg::ans_cfg_t  cfg,
  output ans_pkg::ans_push_t push
);
  import ans_pkg::*;

  logic       s1_valid_r;
  logic [7:0] byte_r;
  logic       pe_r;
  ans_state_t state_r;
  ans_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= accept;
      state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      pe_r   <= packet_end;
    end
  end

  always_comb begin : step_logic
    ans_state_t st;
    ans_push_t  pl;
    logic       is_code;
    logic       fin;
    logic       fin_plast;
    logic       idr;
    logic [1:0] dv_next;
    logic [2:0] nz;
    logic [2:0] nadd;
    logic [7:0] cb;

    st        = state_r;
    pl        = '0;
    idr       = 1'b0;
    cb        = ZERO_BYTE;
    nz        = '0;
    nadd      = '0;
    fin       = 1'b0;
    fin_plast = 1'b0;
    dv_next   = state_r.delay_valid;
    is_code   = (byte_r == START_CODE_END) && (state_r.delay_valid >= 2'd2);

    // plan: a run of zeros released from the window, then maybe this byte
    if (is_code) begin
      fin       = 1'b1;
      fin_plast = pe_r;
      dv_next   = '0;
    end else if (byte_r == ZERO_BYTE) begin
      if (state_r.delay_valid == ZERO_RUN_MAX) begin
        nz = 3'd1;
      end else begin
        dv_next = state_r.delay_valid + 2'd1;
      end
      if (pe_r) begin
        nz        = nz + {1'b0, dv_next};
        dv_next   = '0;
        fin       = 1'b1;
        fin_plast = 1'b1;
      end
      nadd = nz;
    end else begin
      nz        = {1'b0, state_r.delay_valid};
      nadd      = nz + 3'd1;
      dv_next   = '0;
      fin       = pe_r;
      fin_plast = 1'b1;
    end

    for (int i = 0; i < ANS_MAX_ADDS; i++) begin
      if (3'(i) < nadd) begin
        cb = (3'(i) < nz) ? ZERO_BYTE : byte_r;
        if (st.inside_unit) begin
          if (st.header_pending) begin
            // header byte: fix type, set tracking and start code bytes
            if (cfg.codec_select) begin
              st.current_type = 6'((cb & H265_TYPE_MASK) >> 1);
              if (st.current_type == H265_VPS) st.seen_sets[SEEN_VPS] = 1'b1;
              if (st.current_type == H265_SPS) st.seen_sets[SEEN_SPS] = 1'b1;
              if (st.current_type == H265_PPS) st.seen_sets[SEEN_PPS] = 1'b1;
              idr = st.current_type inside {H265_IDR_RADL, H265_IDR_NLP};
            end else begin
              st.current_type = 6'(cb & H264_TYPE_MASK);
              if (st.current_type == H264_SPS) st.seen_sets[SEEN_SPS] = 1'b1;
              if (st.current_type == H264_PPS) st.seen_sets[SEEN_PPS] = 1'b1;
              idr = (st.current_type == H264_IDR);
            end
            st.unit_due = idr && cfg.repeat_parameter_sets &&
                          sets_known(st.seen_sets, cfg.codec_select);
            if (!cfg.codec_select && st.current_type == H264_SPS) begin
              st.profile_bytes_left = PROFILE_BYTES;
              st.profile_capture    = '0;
            end else begin
              st.profile_bytes_left = '0;
            end
            st.header_pending = 1'b0;
            if (cfg.keep_start_code) begin
              if (st.code_long) begin
                pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
                  make_entry(st, cfg, ZERO_BYTE, 1'b1, 1'b0, 1'b0);
                pl.cnt = pl.cnt + 4'd1;
              end
              pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
                make_entry(st, cfg, ZERO_BYTE, !st.code_long, 1'b0, 1'b0);
              pl.cnt = pl.cnt + 4'd1;
              pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
                make_entry(st, cfg, ZERO_BYTE, 1'b0, 1'b0, 1'b0);
              pl.cnt = pl.cnt + 4'd1;
              pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
                make_entry(st, cfg, START_CODE_END, 1'b0, 1'b0, 1'b0);
              pl.cnt = pl.cnt + 4'd1;
            end
            st.held_byte  = cb;
            st.held_first = !cfg.keep_start_code;
            st.held_valid = 1'b1;
          end else begin
            // ordinary content byte: release the held one
            if (st.held_valid) begin
              pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
                make_entry(st, cfg, st.held_byte, st.held_first, 1'b0, 1'b0);
              pl.cnt = pl.cnt + 4'd1;
            end
            st.held_byte  = cb;
            st.held_first = 1'b0;
            st.held_valid = 1'b1;
            if (st.profile_bytes_left != 2'd0) begin
              st.profile_capture    = {st.profile_capture[15:0], cb};
              st.profile_bytes_left = st.profile_bytes_left - 2'd1;
              if (st.profile_bytes_left == 2'd0) st.profile_value = st.profile_capture;
            end
          end
        end
      end
    end

    // close the unit: held byte is its last
    if (fin) begin
      if (st.held_valid) begin
        pl.ent[pl.cnt[ANS_PIDX_W-1:0]] =
          make_entry(st, cfg, st.held_byte, st.held_first, 1'b1, fin_plast);
        pl.cnt        = pl.cnt + 4'd1;
        st.held_valid = 1'b0;
      end
      if (st.profile_bytes_left != 2'd0) begin
        st.profile_value      = '0;
        st.profile_bytes_left = '0;
      end
    end

    if (is_code) begin
      st.code_long      = (state_r.delay_valid == ZERO_RUN_MAX);
      st.inside_unit    = !pe_r;
      st.header_pending = !pe_r;
    end else if (pe_r) begin
      st.inside_unit    = 1'b0;
      st.header_pending = 1'b0;
    end
    st.delay_valid = dv_next;

    if (!s1_valid_r) begin
      st     = state_r;
      pl.cnt = '0;
    end

    state_nxt = st;
    push      = pl;
  end

  a_header_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.header_pending |-> state_r.inside_unit && !state_r.held_valid)
    else $error("header pending outside a unit or with a held byte");

  a_held_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.held_valid |-> state_r.inside_unit)
    else $error("held byte survives outside a unit");

  a_profile_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.profile_bytes_left != 2'd0) |-> state_r.inside_unit)
    else $error("profile capture left open after unit end");

endmodule

/* sv/ans_fifo.sv */
// result queue: up to eight writes per cycle, one read per cycle while the output channel is ready
`timescale 1ns / 1ps

module ans_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ans_pkg::ans_push_t push,
  output logic               has_room,
  ans_out_if.source          out_ch
);
  import ans_pkg::*;

  localparam int DEPTH      = ANS_QUEUE_DEPTH;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = AW + 1;
  localparam int ROOM_LEVEL = DEPTH - 2 * ANS_MAX_PUSH;

  ans_entry_t    mem_r [DEPTH];
  logic [AW-1:0] off [DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          pop;
  ans_entry_t    head;

  assign pop       = out_ch.valid && out_ch.ready;
  assign count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  assign has_room  = (count_r <= CW'(ROOM_LEVEL));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      off[i] = AW'(i) - wptr_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(off[i]) < CW'(push.cnt)) begin
        mem_r[i] <= push.ent[off[i][ANS_PIDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + AW'(push.cnt);
      if (pop) rptr_r <= rptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

  assign head                 = mem_r[rptr_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.out_byte      = head.data;
  assign out_ch.unit_type     = head.utype;
  assign out_ch.unit_first    = head.is_first;
  assign out_ch.unit_last     = head.is_last;
  assign out_ch.packet_last   = head.pkt_last;
  assign out_ch.config_due    = head.due;
  assign out_ch.sets_ready    = head.ready;
  assign out_ch.profile_level = head.prof;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(count_r) + int'(push.cnt)) <= DEPTH)
    else $error("result queue overflow");

  a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
    has_room |=> int'(count_r) <= ROOM_LEVEL + ANS_MAX_PUSH)
    else $error("queue grew past one burst after room was granted");

endmodule

/* sv/annexb_nal_unit_splitter.sv */
// top level of the annex b nal unit splitter
`timescale 1ns / 1ps
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   in_ch    | sink      | valid / ready        | in_byte, packet_end
//   out_ch   | source    | valid / ready        | out_byte, unit_type, unit_first, unit_last,
//            |           |                      | packet_last, config_due, sets_ready,
//            |           |                      | profile_level
//   apb      | slave     | psel/penable, pready | paddr, pwdata, prdata (codec, keep, repeat)
//
// one input byte per cycle while the queue has room; a byte is registered, classified in one
//   pass and its results are then written into the queue, which the output reads from
//   (bytes that may be start code zeros wait for later bytes)
// one byte can release up to eight result transactions (header with start code bytes,
//   flushed zeros and the last byte at a packet end); the queue drains one per cycle while out_ch.ready is high
// in_ch.ready is low while the queue holds more than 16 of its 32 entries
// rst_n is synchronous: clears the registers, unit tracking, seen sets and the queue

module annexb_nal_unit_splitter (
  input  logic                             clk,
  input  logic                             rst_n,
  ans_in_if.sink                           in_ch,
  ans_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ans_pkg::ANS_PADDR_W-1:0]  paddr,
  input  logic [ans_pkg::ANS_DATA_W-1:0]   pwdata,
  output logic [ans_pkg::ANS_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import ans_pkg::*;

  ans_cfg_t  cfg;
  ans_push_t push;
  logic      has_room;
  logic      accept;

  // input transaction: room is judged on the registered queue level only
  assign in_ch.ready = has_room;
  assign accept      = in_ch.valid && in_ch.ready;

  // configuration registers
  ans_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // start code window, unit state and per-byte tagging
  ans_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .packet_end (in_ch.packet_end),
    .cfg        (cfg),
    .push       (push)
  );

  // tagged bytes wait here for the output side
  ans_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .has_room (has_room),
    .out_ch   (out_ch)
  );

endmodule

/* sim/annexb_nal_unit_splitter_test.sv */
// self-checking testbench for the annex b nal unit splitter: streams, registers, back-pressure
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_test;
  import ans_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // cycles with no transaction on any port before the run is declared hung;
  // the longest quiet stretch of a good run is the receiver hold-off below
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  // idle time after the last result before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ANS_PADDR_W-1:0] paddr;
  logic [ANS_DATA_W-1:0]  pwdata;
  logic [ANS_DATA_W-1:0]  prdata;
  logic                   pready;

  ans_in_if  in_ch();
  ans_out_if out_ch();

  annexb_nal_unit_splitter u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // splitter prediction: mirrors the block state, one call per accepted byte
  // ---------------------------------------------------------------------------

  // register copies, updated when the apb write lands
  logic cfg_codec;
  logic cfg_keep;
  logic cfg_repeat;

  logic        in_unit;       // a start code has been seen in this packet
  logic        hdr_pending;   // next content byte is the nal header
  logic        long_code;     // current unit opened with 00 00 00 01
  logic        unit_due;      // idr unit flagged for parameter set repeat
  logic [5:0]  cur_type;
  logic [1:0]  zero_run;      // trailing zeros not yet classified
  logic [7:0]  held_byte;     // latest content byte, waits to learn if it is last
  logic        held_valid;
  logic        held_first;
  logic [1:0]  prof_left;     // sps bytes still to capture
  logic [23:0] prof_capture;
  logic [23:0] prof_value;
  logic [2:0]  seen_sets;

  ans_entry_t expected_bytes[$];

  function automatic logic sets_complete();
    logic [2:0] need;
    need = cfg_codec ? NEED_H265 : NEED_H264;
    return (seen_sets & need) == need;
  endfunction

  // a byte is queued with the tags valid at this moment
  function automatic void queue_byte(logic [7:0] b, logic first, logic last, logic plast);
    ans_entry_t e;
    e.data     = b;
    e.utype    = cur_type;
    e.is_first = first;
    e.is_last  = last;
    e.pkt_last = plast;
    e.due      = unit_due;
    e.ready    = sets_complete();
    e.prof     = prof_value;
    expected_bytes = {expected_bytes, e};
  endfunction

  // header byte classifies the unit and fixes its type, due flag and prefix
  function automatic void open_unit(logic [7:0] h);
    logic idr;
    if (cfg_codec) begin
      cur_type = 6'((h & H265_TYPE_MASK) >> 1);
      if (cur_type == H265_VPS) seen_sets[SEEN_VPS] = 1'b1;
      if (cur_type == H265_SPS) seen_sets[SEEN_SPS] = 1'b1;
      if (cur_type == H265_PPS) seen_sets[SEEN_PPS] = 1'b1;
      idr = (cur_type == H265_IDR_RADL) || (cur_type == H265_IDR_NLP);
    end else begin
      cur_type = 6'(h & H264_TYPE_MASK);
      if (cur_type == H264_SPS) seen_sets[SEEN_SPS] = 1'b1;
      if (cur_type == H264_PPS) seen_sets[SEEN_PPS] = 1'b1;
      idr = (cur_type == H264_IDR);
    end
    unit_due = idr && cfg_repeat && sets_complete();
    if (!cfg_codec && cur_type == H264_SPS) begin
      prof_left    = PROFILE_BYTES;
      prof_capture = '0;
    end else begin
      prof_left = '0;
    end
    hdr_pending = 1'b0;
    if (cfg_keep) begin
      // the leading zero of a long code carries the first mark
      if (long_code) queue_byte(ZERO_BYTE, 1'b1, 1'b0, 1'b0);
      queue_byte(ZERO_BYTE, !long_code, 1'b0, 1'b0);
      queue_byte(ZERO_BYTE, 1'b0, 1'b0, 1'b0);
      queue_byte(START_CODE_END, 1'b0, 1'b0, 1'b0);
    end
    held_byte  = h;
    held_first = !cfg_keep;
    held_valid = 1'b1;
  endfunction

  function automatic void add_content(logic [7:0] b);
    if (!in_unit) return;
    if (hdr_pending) begin
      open_unit(b);
      return;
    end
    if (held_valid) queue_byte(held_byte, held_first, 1'b0, 1'b0);
    held_byte  = b;
    held_first = 1'b0;
    held_valid = 1'b1;
    if (prof_left != 0) begin
      prof_capture = {prof_capture[15:0], b};
      prof_left--;
      if (prof_left == 0) prof_value = prof_capture;
    end
  endfunction

  function automatic void close_unit(logic plast);
    if (held_valid) begin
      queue_byte(held_byte, held_first, 1'b1, plast);
      held_valid = 1'b0;
    end
    // an sps cut short leaves no profile
    if (prof_left != 0) begin
      prof_value = '0;
      prof_left  = '0;
    end
  endfunction

  function automatic void release_zeros();
    while (zero_run != 0) begin
      add_content(ZERO_BYTE);
      zero_run--;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic pe);
    if (b == START_CODE_END && zero_run >= 2) begin
      close_unit(pe);
      long_code   = (zero_run == ZERO_RUN_MAX);
      zero_run    = '0;
      in_unit     = !pe;
      hdr_pending = !pe;
    end else begin
      if (b == ZERO_BYTE) begin
        // a fourth zero can no longer be part of a start code
        if (zero_run == ZERO_RUN_MAX) add_content(ZERO_BYTE);
        else zero_run++;
      end else begin
        release_zeros();
        add_content(b);
      end
      if (pe) begin
        release_zeros();
        close_unit(1'b1);
        in_unit     = 1'b0;
        hdr_pending = 1'b0;
      end
    end
  endfunction

  function automatic void reset_prediction();
    cfg_codec    = 1'b0;
    cfg_keep     = 1'b0;
    cfg_repeat   = 1'b0;
    in_unit      = 1'b0;
    hdr_pending  = 1'b0;
    long_code    = 1'b0;
    unit_due     = 1'b0;
    cur_type     = '0;
    zero_run     = '0;
    held_byte    = '0;
    held_valid   = 1'b0;
    held_first   = 1'b0;
    prof_left    = '0;
    prof_capture = '0;
    prof_value   = '0;
    seen_sets    = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // shared run state
  // ---------------------------------------------------------------------------

  logic failed;
  logic gaps_on;       // random idling on both sides; off gives back-to-back stretches
  logic hold_req;      // asks the receiver for one long hold-off
  int   hold_left;
  int   stall_left;
  int   bytes_sent;
  int   quiet_cycles;

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls, and the checker
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    ans_entry_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result transaction, out_byte 0x%0h", out_ch.out_byte);
        failed = 1'b1;
      end else begin
        e = expected_bytes.pop_front();
        check_field("out_byte",      32'(e.data),     32'(out_ch.out_byte));
        check_field("unit_type",     32'(e.utype),    32'(out_ch.unit_type));
        check_field("unit_first",    32'(e.is_first), 32'(out_ch.unit_first));
        check_field("unit_last",     32'(e.is_last),  32'(out_ch.unit_last));
        check_field("packet_last",   32'(e.pkt_last), 32'(out_ch.packet_last));
        check_field("config_due",    32'(e.due),      32'(out_ch.config_due));
        check_field("sets_ready",    32'(e.ready),    32'(out_ch.sets_ready));
        check_field("profile_level", 32'(e.prof),     32'(out_ch.profile_level));
      end
      stall_left = gaps_on ? $urandom_range(0, 6) : 0;
    end
  end

  // watchdog: any transaction on any port restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // one byte transaction on the input channel, predicted when accepted
  task automatic send_byte(input logic [7:0] b, input logic pe);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.packet_end <= pe;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, pe);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // stop offering, let every predicted byte come out, then give the block
  // time to finish bytes that produce nothing
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write then read back; the block must be idle
  task automatic write_reg(input ans_reg_t r, input logic v);
    logic [ANS_PADDR_W-1:0] addr;
    addr = ANS_PADDR_W'(int'(r) * 4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // upper bits are don't-care for a one bit register
    pwdata  <= {31'($urandom()), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_CODEC_SELECT: cfg_codec  = v;
      REG_KEEP_START:   cfg_keep   = v;
      REG_REPEAT_SETS:  cfg_repeat = v;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("register readback", 32'(v), 32'(prdata[0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic codec, input logic keep, input logic rep);
    drain();
    write_reg(REG_CODEC_SELECT, codec);
    write_reg(REG_KEEP_START, keep);
    write_reg(REG_REPEAT_SETS, rep);
  endtask

  // ---------------------------------------------------------------------------
  // stream generation
  // ---------------------------------------------------------------------------

  // payload byte biased toward zeros and ones so that start codes and
  // zero runs show up inside units
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return ZERO_BYTE;
    if (pick == 4) return START_CODE_END;
    return 8'($urandom());
  endfunction

  // nal header: mostly parameter sets, idr and slices, now and then anything
  function automatic logic [7:0] nal_header();
    logic [5:0] t;
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return ZERO_BYTE;
    if (pick == 1) return 8'($urandom());
    if (cfg_codec) begin
      case ($urandom_range(0, 5))
        0: t = H265_VPS;
        1: t = H265_SPS;
        2: t = H265_PPS;
        3: t = H265_IDR_RADL;
        4: t = H265_IDR_NLP;
        default: t = 6'($urandom_range(0, 63));
      endcase
      return {1'($urandom()), t, 1'($urandom())};
    end
    case ($urandom_range(0, 4))
      0: t = H264_SPS;
      1: t = H264_PPS;
      2: t = H264_IDR;
      default: t = 6'($urandom_range(0, 31));
    endcase
    return {3'($urandom()), t[4:0]};
  endfunction

  function automatic void push_start_code(ref byte_q_t pkt);
    if ($urandom_range(0, 2) == 0) pkt = {pkt, ZERO_BYTE};
    pkt = {pkt, ZERO_BYTE};
    pkt = {pkt, ZERO_BYTE};
    pkt = {pkt, START_CODE_END};
  endfunction

  task automatic send_random_packet();
    byte_q_t pkt;
    int units;
    int len;
    if ($urandom_range(0, 9) == 0) begin
      // noise packet, structure only by chance
      len = $urandom_range(1, 12);
      repeat (len) pkt = {pkt, payload_byte()};
    end else begin
      // leading bytes before any start code get dropped
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        repeat (len) pkt = {pkt, payload_byte()};
      end
      units = $urandom_range(1, 3);
      repeat (units) begin
        push_start_code(pkt);
        pkt = {pkt, nal_header()};
        len = $urandom_range(0, 6);
        repeat (len) pkt = {pkt, payload_byte()};
      end
      // packet that ends on a start code
      if ($urandom_range(0, 5) == 0) push_start_code(pkt);
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    send_packet(pkt);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // h264 basics: garbage before the first code, long code, sps with its
  // profile bytes, pps; extremes of the byte value
  task automatic test_directed_h264();
    set_mode(1'b0, 1'b0, 1'b0);
    send_packet('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h64, 8'h00, 8'h28,
                  8'h00, 8'h00, 8'h01, 8'h68, 8'hEE});
  endtask

  // header zero taken as the prefix of the next code (empty unit), idr unit,
  // a zero run longer than a code, a packet that ends on a start code, and a
  // packet with no unit at all
  task automatic test_edge_cases();
    set_mode(1'b0, 1'b1, 1'b1);
    send_packet('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
    send_packet('{8'h00});
  endtask

  task automatic test_random_phase(input logic codec, input logic keep, input logic rep,
                                   input int n_bytes);
    int start;
    set_mode(codec, keep, rep);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_packet();
  endtask

  // receiver holds off while a long unit streams in back to back, so the
  // result queue fills and the input channel has to stall
  task automatic test_backpressure();
    byte_q_t pkt;
    drain();
    pkt = '{8'h00, 8'h00, 8'h01, 8'h41};
    repeat (60) pkt = {pkt, 8'($urandom_range(2, 255))};
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_packet(pkt);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.packet_end = 1'b0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    failed           = 1'b0;
    gaps_on          = 1'b1;
    hold_req         = 1'b0;
    hold_left        = 0;
    stall_left       = 0;
    bytes_sent       = 0;
    quiet_cycles     = 0;
    reset_prediction();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_h264();
    test_edge_cases();
    test_random_phase(1'b0, 1'b1, 1'b1, 50);
    // switch codec with sets carried over from h264
    test_random_phase(1'b1, 1'b0, 1'b1, 50);
    test_random_phase(1'b1, 1'b1, 1'b1, 50);
    test_backpressure();
    test_random_phase(1'b0, 1'b0, 1'b1, 40);
    test_random_phase(1'b1, 1'b1, 1'b0, 40);

    drain();
    if (!failed && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
